// File: rtl/core/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants
// Default sizes, register reset values, register indexes and the control
// group that travels down the flush chain.
// ----------------------------------------------------------------------------
package ssd_pkg;

	// Default sizes for the top-level parameters
	localparam int DEF_WINDOW_ORDER = 4;
	localparam int DEF_SAMPLE_BITS  = 16;
	localparam int DEF_RUN_BITS     = 12;

	// Register field widths (fixed)
	localparam int THR_W      = 16;
	localparam int HOLD_W     = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register reset values: 1.9 g at 2048 per g, 150 deg/s, hold counts
	localparam logic signed [THR_W-1:0] RST_ACCEL_THR  = 16'sd3891;
	localparam logic signed [THR_W-1:0] RST_GYRO_THR   = 16'sd2460;
	localparam logic [HOLD_W-1:0]       RST_ACCEL_HOLD = 12'd200;
	localparam logic [HOLD_W-1:0]       RST_GYRO_HOLD  = 12'd100;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACCEL_THR  = 2'd0,
		CFG_GYRO_THR   = 2'd1,
		CFG_ACCEL_HOLD = 2'd2,
		CFG_GYRO_HOLD  = 2'd3
	} cfg_reg_t;

	// Control group handed from one flush cell to the next
	typedef struct packed {
		logic valid;   // a record end occupies this slot
		logic impact;  // acceleration channel tripped so far
		logic fall;    // rotation channel tripped so far
	} cell_ctl_t;

endpackage

// File: rtl/core/ssd_window.sv
// ----------------------------------------------------------------------------
// ssd_window: sample shift row and running window sum, one channel
// Holds the newest SPAN samples, newest first, and their sum. Outputs show
// the values after the shift that the current transfer would cause.
// ----------------------------------------------------------------------------
module ssd_window #(
	parameter int SAMPLE_BITS = ssd_pkg::DEF_SAMPLE_BITS,
	parameter int SPAN        = 5,
	parameter int H           = 2,
	parameter int SUM_W       = 19
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift,
	input  logic                          clear,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic signed [SUM_W-1:0]       sum_o,
	output logic signed [SAMPLE_BITS-1:0] tail_o,
	output logic signed [SAMPLE_BITS-1:0] taps_o [H]
);

	logic signed [SAMPLE_BITS-1:0] win_q [SPAN];
	logic signed [SUM_W-1:0]       sum_q;

	// Slots past the fill level are zero, so the oldest slot can always go
	assign sum_o  = sum_q - SUM_W'(win_q[SPAN-1]) + SUM_W'(sample);
	assign tail_o = win_q[SPAN-2];

	always_comb begin
		for (int k = 0; k < H; k++) begin
			taps_o[k] = win_q[H+k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < SPAN; d++) begin
				win_q[d] <= '0;
			end
			sum_q <= '0;
		end else if (shift) begin
			if (clear) begin
				for (int d = 0; d < SPAN; d++) begin
					win_q[d] <= '0;
				end
				sum_q <= '0;
			end else begin
				win_q[0] <= sample;
				for (int d = 1; d < SPAN; d++) begin
					win_q[d] <= win_q[d-1];
				end
				sum_q <= sum_o;
			end
		end
	end

endmodule

// File: rtl/core/ssd_judge.sv
// ----------------------------------------------------------------------------
// ssd_judge: level test and run counter step, one channel
// Tests sum >= threshold * count and advances the run counter and trip flag.
// ----------------------------------------------------------------------------
module ssd_judge #(
	parameter int SUM_W    = 19,
	parameter int CNT_W    = 3,
	parameter int RUN_BITS = ssd_pkg::DEF_RUN_BITS
) (
	input  logic                              act,
	input  logic signed [SUM_W-1:0]           sum,
	input  logic [CNT_W-1:0]                  cnt,
	input  logic signed [ssd_pkg::THR_W-1:0]  thr,
	input  logic [ssd_pkg::HOLD_W-1:0]        hold,
	input  logic [RUN_BITS-1:0]               run_i,
	input  logic                              flag_i,
	output logic [RUN_BITS-1:0]               run_o,
	output logic                              flag_o
);

	localparam int PROD_W = ssd_pkg::THR_W + CNT_W + 1;
	localparam int CMP_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
	localparam int HC_W   = (RUN_BITS > ssd_pkg::HOLD_W) ? RUN_BITS : ssd_pkg::HOLD_W;

	logic signed [PROD_W-1:0] thr_x, cnt_x, prod;
	logic signed [CMP_W-1:0]  sum_x, prod_x;
	logic                     pass, held;

	assign thr_x  = PROD_W'(thr);
	assign cnt_x  = signed'(PROD_W'(cnt));
	assign prod   = thr_x * cnt_x;
	assign sum_x  = CMP_W'(sum);
	assign prod_x = CMP_W'(prod);
	assign pass   = (sum_x >= prod_x);
	assign held   = (HC_W'(run_i) >= HC_W'(hold));

	always_comb begin
		run_o  = run_i;
		flag_o = flag_i;
		if (act) begin
			if (pass) begin
				flag_o = flag_i | held;
				if (!(&run_i)) begin
					run_o = run_i + 1'b1;
				end
			end else begin
				run_o = '0;
			end
		end
	end

endmodule

// File: rtl/core/ssd_flush_cell.sv
// ----------------------------------------------------------------------------
// ssd_flush_cell: one trailing-window judgment of a finished record
// Cell M judges the center M-1 samples back from the newest sample, whose
// window holds the newest M+H samples, then drops the oldest of them for the
// next cell and hands the record state on.
// ----------------------------------------------------------------------------
module ssd_flush_cell #(
	parameter int SAMPLE_BITS = ssd_pkg::DEF_SAMPLE_BITS,
	parameter int SUM_W       = 19,
	parameter int CNT_W       = 3,
	parameter int RUN_BITS    = ssd_pkg::DEF_RUN_BITS,
	parameter int H           = 2,
	parameter int M           = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic signed [ssd_pkg::THR_W-1:0] accel_thr,
	input  logic signed [ssd_pkg::THR_W-1:0] gyro_thr,
	input  logic [ssd_pkg::HOLD_W-1:0]       accel_hold,
	input  logic [ssd_pkg::HOLD_W-1:0]       gyro_hold,
	input  ssd_pkg::cell_ctl_t               ctl_i,
	input  logic [RUN_BITS-1:0]              accel_run_i,
	input  logic [RUN_BITS-1:0]              gyro_run_i,
	input  logic signed [SUM_W-1:0]          accel_sum_i,
	input  logic signed [SUM_W-1:0]          gyro_sum_i,
	input  logic [CNT_W-1:0]                 ss_i,
	input  logic signed [SAMPLE_BITS-1:0]    accel_taps_i [H],
	input  logic signed [SAMPLE_BITS-1:0]    gyro_taps_i [H],
	output ssd_pkg::cell_ctl_t               ctl_o,
	output logic [RUN_BITS-1:0]              accel_run_o,
	output logic [RUN_BITS-1:0]              gyro_run_o,
	output logic signed [SUM_W-1:0]          accel_sum_o,
	output logic signed [SUM_W-1:0]          gyro_sum_o,
	output logic [CNT_W-1:0]                 ss_o,
	output logic signed [SAMPLE_BITS-1:0]    accel_taps_o [H],
	output logic signed [SAMPLE_BITS-1:0]    gyro_taps_o [H]
);

	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(M + H);
	localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(M);

	logic                act;
	logic [CNT_W-1:0]    cnt;
	logic [RUN_BITS-1:0] accel_run_nx, gyro_run_nx;
	logic                impact_nx, fall_nx;

	// Short records: centers that never existed are skipped, windows clip
	assign act = (ss_i >= CNT_MIN);
	assign cnt = (ss_i < CNT_CAP) ? ss_i : CNT_CAP;

	ssd_judge #(.SUM_W(SUM_W), .CNT_W(CNT_W), .RUN_BITS(RUN_BITS)) u_accel_judge (
		.act    (act),
		.sum    (accel_sum_i),
		.cnt    (cnt),
		.thr    (accel_thr),
		.hold   (accel_hold),
		.run_i  (accel_run_i),
		.flag_i (ctl_i.impact),
		.run_o  (accel_run_nx),
		.flag_o (impact_nx)
	);

	ssd_judge #(.SUM_W(SUM_W), .CNT_W(CNT_W), .RUN_BITS(RUN_BITS)) u_gyro_judge (
		.act    (act),
		.sum    (gyro_sum_i),
		.cnt    (cnt),
		.thr    (gyro_thr),
		.hold   (gyro_hold),
		.run_i  (gyro_run_i),
		.flag_i (ctl_i.fall),
		.run_o  (gyro_run_nx),
		.flag_o (fall_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (adv) begin
			ctl_o.valid  <= ctl_i.valid;
			ctl_o.impact <= impact_nx;
			ctl_o.fall   <= fall_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			accel_run_o  <= accel_run_nx;
			gyro_run_o   <= gyro_run_nx;
			accel_sum_o  <= accel_sum_i - SUM_W'(accel_taps_i[M-1]);
			gyro_sum_o   <= gyro_sum_i - SUM_W'(gyro_taps_i[M-1]);
			ss_o         <= ss_i;
			accel_taps_o <= accel_taps_i;
			gyro_taps_o  <= gyro_taps_i;
		end
	end

endmodule

// File: rtl/core/smoothed_sustained_threshold_detector_unit.sv
// ----------------------------------------------------------------------------
// smoothed_sustained_threshold_detector_unit: record-level hazard detector
// Smooths paired acceleration and rotation-rate samples with a centered
// moving average and flags a channel whose level holds long enough.
// ----------------------------------------------------------------------------
//
// Channel  Handshake             Payload
// -------  --------------------  ---------------------------------------------
// in       in_valid / in_ready   accel_sample, gyro_sample, last_sample
// out      out_valid / out_ready hazard, impact_found, fall_found
// cfg      cfg_we (no wait)      cfg_index, cfg_data
//
// One sample transfer per cycle while in_ready is high. A record's result
// passes from its last-sample transfer through the window snapshot, the chain
// entry register, the H flush cells (H = WINDOW_ORDER/2) and the output reg.
// Reset is asynchronous and clears all record state at once; no sweep.
// in_ready drops only while a finished result sits at the chain end and
// the output register is still held by out_ready low.
//
// Structure:
//   window rows  - per-channel shift row of the newest 2H+1 samples and
//                  their running sum; cleared by the last sample of a record.
//   run stage    - judges the center H samples back once enough samples are
//                  in, and keeps the open run counters of the current record.
//   flush chain  - H cells; a finished record walks through them, one
//                  trailing window judged per cell, largest window first.
//   output reg   - folds open runs into the flags and holds the result.
// ----------------------------------------------------------------------------
module smoothed_sustained_threshold_detector_unit #(
	parameter int WINDOW_ORDER = ssd_pkg::DEF_WINDOW_ORDER,
	parameter int SAMPLE_BITS  = ssd_pkg::DEF_SAMPLE_BITS,
	parameter int RUN_BITS     = ssd_pkg::DEF_RUN_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        accel_sample,
	input  logic signed [SAMPLE_BITS-1:0]        gyro_sample,
	input  logic                                 last_sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 hazard,
	output logic                                 impact_found,
	output logic                                 fall_found,
	input  logic                                 cfg_we,
	input  logic [ssd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ssd_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int H     = WINDOW_ORDER / 2;
	localparam int SPAN  = 2 * H + 1;
	localparam int SUM_W = SAMPLE_BITS + $clog2(SPAN);
	localparam int CNT_W = $clog2(SPAN + 1);

	// ---------------- configuration registers ----------------
	logic signed [ssd_pkg::THR_W-1:0] accel_thr_q, gyro_thr_q;
	logic [ssd_pkg::HOLD_W-1:0]       accel_hold_q, gyro_hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_thr_q  <= ssd_pkg::RST_ACCEL_THR;
			gyro_thr_q   <= ssd_pkg::RST_GYRO_THR;
			accel_hold_q <= ssd_pkg::RST_ACCEL_HOLD;
			gyro_hold_q  <= ssd_pkg::RST_GYRO_HOLD;
		end else if (cfg_we) begin
			case (ssd_pkg::cfg_reg_t'(cfg_index))
				ssd_pkg::CFG_ACCEL_THR:  accel_thr_q  <= cfg_data;
				ssd_pkg::CFG_GYRO_THR:   gyro_thr_q   <= cfg_data;
				ssd_pkg::CFG_ACCEL_HOLD: accel_hold_q <= cfg_data[ssd_pkg::HOLD_W-1:0];
				ssd_pkg::CFG_GYRO_HOLD:  gyro_hold_q  <= cfg_data[ssd_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	// The whole pipe moves together; it halts only when a result reaches the
	// chain end and the output register cannot take it.
	ssd_pkg::cell_ctl_t ctl_out [H];
	logic               adv, accept;
	logic               out_valid_q;

	assign adv      = !(ctl_out[H-1].valid && out_valid_q && !out_ready);
	assign accept   = in_valid && adv;
	assign in_ready = adv;

	// ---------------- window rows ----------------
	logic signed [SUM_W-1:0]       accel_sum_nx, gyro_sum_nx;
	logic signed [SAMPLE_BITS-1:0] accel_tail_nx, gyro_tail_nx;
	logic signed [SAMPLE_BITS-1:0] accel_taps_nx [H];
	logic signed [SAMPLE_BITS-1:0] gyro_taps_nx [H];

	ssd_window #(.SAMPLE_BITS(SAMPLE_BITS), .SPAN(SPAN), .H(H), .SUM_W(SUM_W)) u_accel_win (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (accept),
		.clear  (last_sample),
		.sample (accel_sample),
		.sum_o  (accel_sum_nx),
		.tail_o (accel_tail_nx),
		.taps_o (accel_taps_nx)
	);

	ssd_window #(.SAMPLE_BITS(SAMPLE_BITS), .SPAN(SPAN), .H(H), .SUM_W(SUM_W)) u_gyro_win (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (accept),
		.clear  (last_sample),
		.sample (gyro_sample),
		.sum_o  (gyro_sum_nx),
		.tail_o (gyro_tail_nx),
		.taps_o (gyro_taps_nx)
	);

	// Fill level of the window, saturating at the full span
	logic [CNT_W-1:0] ss_q, ss_nx;

	assign ss_nx = (ss_q == CNT_W'(SPAN)) ? ss_q : ss_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ss_q <= '0;
		end else if (accept) begin
			ss_q <= last_sample ? '0 : ss_nx;
		end
	end

	// Snapshot of the window after each transfer
	logic                          valid_s1, last_s1;
	logic [CNT_W-1:0]              ss_s1;
	logic signed [SUM_W-1:0]       accel_sum_s1, gyro_sum_s1;
	logic signed [SAMPLE_BITS-1:0] accel_tail_s1, gyro_tail_s1;
	logic signed [SAMPLE_BITS-1:0] accel_taps_s1 [H];
	logic signed [SAMPLE_BITS-1:0] gyro_taps_s1 [H];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1       <= last_sample;
			ss_s1         <= ss_nx;
			accel_sum_s1  <= accel_sum_nx;
			gyro_sum_s1   <= gyro_sum_nx;
			accel_tail_s1 <= accel_tail_nx;
			gyro_tail_s1  <= gyro_tail_nx;
			accel_taps_s1 <= accel_taps_nx;
			gyro_taps_s1  <= gyro_taps_nx;
		end
	end

	// ---------------- run stage ----------------
	// A center is judged once H samples past it are in (front-truncated
	// windows compare against the fill level).
	logic                judge_en;
	logic [RUN_BITS-1:0] accel_run_q, gyro_run_q, accel_run_nx, gyro_run_nx;
	logic                impact_q, fall_q, impact_nx, fall_nx;

	assign judge_en = (ss_s1 > CNT_W'(H));

	ssd_judge #(.SUM_W(SUM_W), .CNT_W(CNT_W), .RUN_BITS(RUN_BITS)) u_accel_judge (
		.act    (judge_en),
		.sum    (accel_sum_s1),
		.cnt    (ss_s1),
		.thr    (accel_thr_q),
		.hold   (accel_hold_q),
		.run_i  (accel_run_q),
		.flag_i (impact_q),
		.run_o  (accel_run_nx),
		.flag_o (impact_nx)
	);

	ssd_judge #(.SUM_W(SUM_W), .CNT_W(CNT_W), .RUN_BITS(RUN_BITS)) u_gyro_judge (
		.act    (judge_en),
		.sum    (gyro_sum_s1),
		.cnt    (ss_s1),
		.thr    (gyro_thr_q),
		.hold   (gyro_hold_q),
		.run_i  (gyro_run_q),
		.flag_i (fall_q),
		.run_o  (gyro_run_nx),
		.flag_o (fall_nx)
	);

	// Record state; handed to the flush chain and cleared on the last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_run_q <= '0;
			gyro_run_q  <= '0;
			impact_q    <= 1'b0;
			fall_q      <= 1'b0;
		end else if (adv && valid_s1) begin
			if (last_s1) begin
				accel_run_q <= '0;
				gyro_run_q  <= '0;
				impact_q    <= 1'b0;
				fall_q      <= 1'b0;
			end else begin
				accel_run_q <= accel_run_nx;
				gyro_run_q  <= gyro_run_nx;
				impact_q    <= impact_nx;
				fall_q      <= fall_nx;
			end
		end
	end

	// Chain entry: first trailing window is the newest 2H samples
	ssd_pkg::cell_ctl_t            ctl_s2;
	logic [RUN_BITS-1:0]           accel_run_s2, gyro_run_s2;
	logic signed [SUM_W-1:0]       accel_sum_s2, gyro_sum_s2;
	logic [CNT_W-1:0]              ss_s2;
	logic signed [SAMPLE_BITS-1:0] accel_taps_s2 [H];
	logic signed [SAMPLE_BITS-1:0] gyro_taps_s2 [H];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2.valid  <= valid_s1 && last_s1;
			ctl_s2.impact <= impact_nx;
			ctl_s2.fall   <= fall_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			accel_run_s2  <= accel_run_nx;
			gyro_run_s2   <= gyro_run_nx;
			accel_sum_s2  <= accel_sum_s1 - SUM_W'(accel_tail_s1);
			gyro_sum_s2   <= gyro_sum_s1 - SUM_W'(gyro_tail_s1);
			ss_s2         <= ss_s1;
			accel_taps_s2 <= accel_taps_s1;
			gyro_taps_s2  <= gyro_taps_s1;
		end
	end

	// ---------------- flush chain ----------------
	ssd_pkg::cell_ctl_t            ctl_in [H];
	logic [RUN_BITS-1:0]           accel_run_in [H], gyro_run_in [H];
	logic [RUN_BITS-1:0]           accel_run_out [H], gyro_run_out [H];
	logic signed [SUM_W-1:0]       accel_sum_in [H], gyro_sum_in [H];
	logic signed [SUM_W-1:0]       accel_sum_out [H], gyro_sum_out [H];
	logic [CNT_W-1:0]              ss_in [H], ss_out [H];
	logic signed [SAMPLE_BITS-1:0] accel_taps_in [H][H], gyro_taps_in [H][H];
	logic signed [SAMPLE_BITS-1:0] accel_taps_out [H][H], gyro_taps_out [H][H];

	always_comb begin
		ctl_in[0]        = ctl_s2;
		accel_run_in[0]  = accel_run_s2;
		gyro_run_in[0]   = gyro_run_s2;
		accel_sum_in[0]  = accel_sum_s2;
		gyro_sum_in[0]   = gyro_sum_s2;
		ss_in[0]         = ss_s2;
		accel_taps_in[0] = accel_taps_s2;
		gyro_taps_in[0]  = gyro_taps_s2;
		for (int k = 1; k < H; k++) begin
			ctl_in[k]        = ctl_out[k-1];
			accel_run_in[k]  = accel_run_out[k-1];
			gyro_run_in[k]   = gyro_run_out[k-1];
			accel_sum_in[k]  = accel_sum_out[k-1];
			gyro_sum_in[k]   = gyro_sum_out[k-1];
			ss_in[k]         = ss_out[k-1];
			accel_taps_in[k] = accel_taps_out[k-1];
			gyro_taps_in[k]  = gyro_taps_out[k-1];
		end
	end

	// Cell j judges the center H-j-1 samples back from the newest sample
	for (genvar j = 0; j < H; j++) begin : g_flush
		ssd_flush_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.SUM_W       (SUM_W),
			.CNT_W       (CNT_W),
			.RUN_BITS    (RUN_BITS),
			.H           (H),
			.M           (H - j)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.adv          (adv),
			.accel_thr    (accel_thr_q),
			.gyro_thr     (gyro_thr_q),
			.accel_hold   (accel_hold_q),
			.gyro_hold    (gyro_hold_q),
			.ctl_i        (ctl_in[j]),
			.accel_run_i  (accel_run_in[j]),
			.gyro_run_i   (gyro_run_in[j]),
			.accel_sum_i  (accel_sum_in[j]),
			.gyro_sum_i   (gyro_sum_in[j]),
			.ss_i         (ss_in[j]),
			.accel_taps_i (accel_taps_in[j]),
			.gyro_taps_i  (gyro_taps_in[j]),
			.ctl_o        (ctl_out[j]),
			.accel_run_o  (accel_run_out[j]),
			.gyro_run_o   (gyro_run_out[j]),
			.accel_sum_o  (accel_sum_out[j]),
			.gyro_sum_o   (gyro_sum_out[j]),
			.ss_o         (ss_out[j]),
			.accel_taps_o (accel_taps_out[j]),
			.gyro_taps_o  (gyro_taps_out[j])
		);
	end

	// ---------------- output register ----------------
	// A run still open at the record end counts as a trip.
	logic res_impact, res_fall, res_load;
	logic out_impact_q, out_fall_q, out_hazard_q;

	assign res_impact = ctl_out[H-1].impact | (|accel_run_out[H-1]);
	assign res_fall   = ctl_out[H-1].fall | (|gyro_run_out[H-1]);
	assign res_load   = ctl_out[H-1].valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_impact_q <= res_impact;
			out_fall_q   <= res_fall;
			out_hazard_q <= res_impact | res_fall;
		end
	end

	assign out_valid    = out_valid_q;
	assign hazard       = out_hazard_q;
	assign impact_found = out_impact_q;
	assign fall_found   = out_fall_q;

`ifndef SYNTHESIS
	// Record state starts clean after a record end passes the run stage
	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s1 && last_s1) |=>
		(accel_run_q == '0 && gyro_run_q == '0 && !impact_q && !fall_q))
		else $error("run state not cleared after record end");

	// Fill level never passes the span
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ss_q <= CNT_W'(SPAN))
		else $error("window fill level out of range");

	// A new result comes only from the chain end
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctl_out[H-1].valid))
		else $error("result without a record at the chain end");

	// A halted pipe keeps its finished record at the chain end
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> ctl_out[H-1].valid)
		else $error("finished record lost during stall");
`endif

endmodule
